// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FISD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication violated");

// antecedent implies consequent in the next cycle
`define FISD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

// ----- rtl/core/fisd_pkg.sv -----
// ----------------------------------------------------------------------------
// fisd_pkg
// constants and helper functions for the reciprocal square root core
// ----------------------------------------------------------------------------
package fisd_pkg;

	localparam logic [63:0] MAGIC     = 64'h5fe6eb50c7b537a9;
	localparam logic [63:0] CANON_NAN = 64'h7FF8000000000000;
	localparam logic [63:0] ONE_P5    = 64'h3FF8000000000000;
	localparam logic [10:0] EXP_MAX   = 11'h7FF;

	localparam int FMUL_LAT  = 7;
	localparam int FADD_LAT  = 6;
	localparam int TOTAL_LAT = 1 + 3 * FMUL_LAT + FADD_LAT;

	// leading zero count of the 106-bit product
	function automatic logic [6:0] lzc106(input logic [105:0] v);
		logic [6:0] n;
		logic       found;
		n     = '0;
		found = 1'b0;
		for (int i = 105; i >= 0; i--) begin
			if (!found && v[i]) begin
				n     = 7'(105 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	// leading zero count of the 57-bit sum
	function automatic logic [5:0] lzc57(input logic [56:0] v);
		logic [5:0] n;
		logic       found;
		n     = '0;
		found = 1'b0;
		for (int i = 56; i >= 0; i--) begin
			if (!found && v[i]) begin
				n     = 6'(56 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

// ----- rtl/core/fast_inverse_sqrt_double_core.sv -----
// ----------------------------------------------------------------------------
// fast_inverse_sqrt_double_core
// approximate binary64 reciprocal square root with one newton step
// ----------------------------------------------------------------------------
// usage:
//   raise start with a binary64 pattern on operand_bits; the beat is taken at
//   that edge whenever busy is low. busy stays low: the datapath is a fully
//   pipelined chain with no back pressure, so a new beat can enter every cycle.
//   the result appears on result_bits with done high for exactly one cycle,
//   once the beat has passed through the whole pipeline (1 guess stage, three
//   7-stage multipliers and one 6-stage adder).
//   throughput is one beat per cycle.
//   the receiver cannot stall the block: a result is shown once and must be
//   captured in that cycle.
//   reset clears all valid bits; beats in flight are dropped and no done pulse
//   follows. any nan result is given as the canonical quiet nan.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fast_inverse_sqrt_double_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] operand_bits,
	output logic        done,
	output logic [63:0] result_bits
);

	localparam int GD_DEPTH = 2 * fisd_pkg::FMUL_LAT + fisd_pkg::FADD_LAT;

	assign busy = 1'b0;

	// guess and half, stage 1
	logic [10:0] x_exp;
	logic [52:0] x_sub_sig;
	logic        half_inc;
	logic [62:0] half_mag;
	logic [63:0] half_c, g_c;

	always_comb begin
		x_exp     = operand_bits[62:52];
		x_sub_sig = {x_exp[0], operand_bits[51:0]};
		half_inc  = x_sub_sig[0] & x_sub_sig[1];
		half_mag  = {11'b0, x_sub_sig[52:1]} + {62'b0, half_inc};
		if (x_exp == fisd_pkg::EXP_MAX) begin
			half_c = operand_bits;
		end else if (x_exp >= 11'd2) begin
			half_c = {operand_bits[63], x_exp - 11'd1, operand_bits[51:0]};
		end else begin
			half_c = {operand_bits[63], half_mag};
		end
		g_c = fisd_pkg::MAGIC - {operand_bits[63], operand_bits[63:1]};
	end

	logic        v_s1;
	logic [63:0] half_s1, g_s1;
	logic [63:0] g_dly_q [GD_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		half_s1    <= half_c;
		g_s1       <= g_c;
		g_dly_q[0] <= g_s1;
		for (int i = 1; i < GD_DEPTH; i++) begin
			g_dly_q[i] <= g_dly_q[i-1];
		end
	end

	// p = half * g
	logic        p_valid;
	logic [63:0] p_bits;

	fisd_fmul u_mul_p (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.a        (half_s1),
		.b        (g_s1),
		.out_valid(p_valid),
		.y        (p_bits)
	);

	// t = p * g
	logic        t_valid;
	logic [63:0] t_bits;

	fisd_fmul u_mul_t (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (p_valid),
		.a        (p_bits),
		.b        (g_dly_q[fisd_pkg::FMUL_LAT - 1]),
		.out_valid(t_valid),
		.y        (t_bits)
	);

	// u = 1.5 - t, six stages
	logic [10:0] t_exp, t_eexp, a_eexp;
	logic [52:0] t_sig, a_sig;
	logic        swap;
	logic [10:0] big_exp_c, small_exp_c;

	always_comb begin
		t_exp       = t_bits[62:52];
		t_eexp      = (t_exp == 11'd0) ? 11'd1 : t_exp;
		t_sig       = {t_exp != 11'd0, t_bits[51:0]};
		a_eexp      = fisd_pkg::ONE_P5[62:52];
		a_sig       = {1'b1, fisd_pkg::ONE_P5[51:0]};
		swap        = t_bits[62:0] > fisd_pkg::ONE_P5[62:0];
		big_exp_c   = swap ? t_eexp : a_eexp;
		small_exp_c = swap ? a_eexp : t_eexp;
	end

	logic        v_a1, v_a2, v_a3, v_a4, v_a5, u_valid;
	logic        nan_a1, nan_a2, nan_a3, nan_a4, nan_a5;
	logic        inf_a1, inf_a2, inf_a3, inf_a4, inf_a5;
	logic        bsg_a1, bsg_a2, bsg_a3, bsg_a4, bsg_a5;
	logic        sub_a1, sub_a2, sub_a3, sub_a4, sub_a5;
	logic [10:0] bexp_a1, bexp_a2, bexp_a3;
	logic [52:0] bsig_a1, ssig_a1;
	logic [10:0] d_a1;
	logic [55:0] bext_a2, sext_a2;
	logic [56:0] sum_a3, sum_a4;
	logic        rsh_a4;
	logic [5:0]  sh_a4;
	logic [11:0] ebase_a4, ebase_a5;
	logic        zero_a4, zero_a5;
	logic [52:0] man_a5;
	logic        grd_a5, stk_a5;
	logic [63:0] u_bits;

	// alignment
	logic [5:0]   d_cl;
	logic [119:0] al_wide;

	always_comb begin
		d_cl    = (|d_a1[10:6]) ? 6'd63 : d_a1[5:0];
		al_wide = {ssig_a1, 3'b0, 64'b0} >> d_cl;
	end

	// normalize control
	logic [5:0]  lz_a;
	logic [5:0]  lzm;
	logic [10:0] emin;
	logic [5:0]  sh_c;

	always_comb begin
		lz_a = fisd_pkg::lzc57(sum_a3);
		lzm  = lz_a - 6'd1;
		emin = bexp_a3 - 11'd1;
		sh_c = ({5'b0, lzm} > emin) ? emin[5:0] : lzm;
	end

	// normalize shift
	logic [55:0] nrm_a;

	always_comb begin
		if (rsh_a4) begin
			nrm_a = {sum_a4[56:2], sum_a4[1] | sum_a4[0]};
		end else begin
			nrm_a = sum_a4[55:0] << sh_a4;
		end
	end

	// round
	logic        a_inc;
	logic [53:0] a_mr;
	logic [63:0] a_pk;
	logic        a_ovf;

	always_comb begin
		a_inc = grd_a5 & (stk_a5 | man_a5[0]);
		a_mr  = {1'b0, man_a5} + {53'b0, a_inc};
		a_pk  = {ebase_a5, 52'b0} + {10'b0, a_mr};
		a_ovf = a_pk[63:52] >= 12'd2047;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_a1    <= 1'b0;
			v_a2    <= 1'b0;
			v_a3    <= 1'b0;
			v_a4    <= 1'b0;
			v_a5    <= 1'b0;
			u_valid <= 1'b0;
		end else begin
			v_a1    <= t_valid;
			v_a2    <= v_a1;
			v_a3    <= v_a2;
			v_a4    <= v_a3;
			v_a5    <= v_a4;
			u_valid <= v_a5;
		end
	end

	always_ff @(posedge clk) begin
		// a1: order operands by magnitude, the subtrahend is -t
		nan_a1  <= (t_exp == fisd_pkg::EXP_MAX) && (t_bits[51:0] != 52'd0);
		inf_a1  <= (t_exp == fisd_pkg::EXP_MAX) && (t_bits[51:0] == 52'd0);
		bsg_a1  <= swap ? ~t_bits[63] : fisd_pkg::ONE_P5[63];
		sub_a1  <= ~t_bits[63] ^ fisd_pkg::ONE_P5[63];
		bexp_a1 <= big_exp_c;
		bsig_a1 <= swap ? t_sig : a_sig;
		ssig_a1 <= swap ? a_sig : t_sig;
		d_a1    <= big_exp_c - small_exp_c;
		// a2: align with guard, round and sticky
		nan_a2  <= nan_a1;
		inf_a2  <= inf_a1;
		bsg_a2  <= bsg_a1;
		sub_a2  <= sub_a1;
		bexp_a2 <= bexp_a1;
		bext_a2 <= {bsig_a1, 3'b0};
		sext_a2 <= {al_wide[119:65], al_wide[64] | (|al_wide[63:0])};
		// a3: add or subtract magnitudes
		nan_a3  <= nan_a2;
		inf_a3  <= inf_a2;
		bsg_a3  <= bsg_a2;
		sub_a3  <= sub_a2;
		bexp_a3 <= bexp_a2;
		sum_a3  <= sub_a2 ? ({1'b0, bext_a2} - {1'b0, sext_a2})
			: ({1'b0, bext_a2} + {1'b0, sext_a2});
		// a4: shift amount and exponent
		nan_a4   <= nan_a3;
		inf_a4   <= inf_a3;
		bsg_a4   <= bsg_a3;
		sub_a4   <= sub_a3;
		sum_a4   <= sum_a3;
		zero_a4  <= (sum_a3 == 57'd0);
		rsh_a4   <= sum_a3[56];
		sh_a4    <= sh_c;
		ebase_a4 <= sum_a3[56] ? {1'b0, bexp_a3} : {1'b0, emin - {5'b0, sh_c}};
		// a5: normalize
		nan_a5   <= nan_a4;
		inf_a5   <= inf_a4;
		bsg_a5   <= bsg_a4;
		sub_a5   <= sub_a4;
		zero_a5  <= zero_a4;
		ebase_a5 <= ebase_a4;
		man_a5   <= nrm_a[55:3];
		grd_a5   <= nrm_a[2];
		stk_a5   <= |nrm_a[1:0];
		// a6: round and pack
		if (nan_a5) begin
			u_bits <= fisd_pkg::CANON_NAN;
		end else if (inf_a5 || (!zero_a5 && a_ovf)) begin
			u_bits <= {bsg_a5, fisd_pkg::EXP_MAX, 52'b0};
		end else if (zero_a5) begin
			u_bits <= {bsg_a5 & ~sub_a5, 63'b0};
		end else begin
			u_bits <= {bsg_a5, a_pk[62:0]};
		end
	end

	// r = g * u
	fisd_fmul u_mul_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (u_valid),
		.a        (g_dly_q[GD_DEPTH - 1]),
		.b        (u_bits),
		.out_valid(done),
		.y        (result_bits)
	);

	`FISD_ASSERT_IMP(a_top_lat, clk, arst_n, done, $past(start, fisd_pkg::TOTAL_LAT))
	`FISD_ASSERT_IMP(a_top_nan_canon, clk, arst_n,
		done && result_bits[62:52] == fisd_pkg::EXP_MAX && result_bits[51:0] != 52'd0,
		result_bits == fisd_pkg::CANON_NAN)
	`FISD_ASSERT_IMP(a_top_nan_in, clk, arst_n,
		done && $past(start && operand_bits[62:52] == fisd_pkg::EXP_MAX
		&& operand_bits[51:0] != 52'd0, fisd_pkg::TOTAL_LAT),
		result_bits == fisd_pkg::CANON_NAN)

endmodule

// ----- rtl/core/fisd_fmul.sv -----
// ----------------------------------------------------------------------------
// fisd_fmul
// seven-stage binary64 multiplier, round to nearest even, full subnormals
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fisd_fmul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        out_valid,
	output logic [63:0] y
);

	// unpack
	logic [10:0] a_exp, b_exp;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

	assign a_exp  = a[62:52];
	assign b_exp  = b[62:52];
	assign a_nan  = (a_exp == fisd_pkg::EXP_MAX) && (a[51:0] != 52'd0);
	assign b_nan  = (b_exp == fisd_pkg::EXP_MAX) && (b[51:0] != 52'd0);
	assign a_inf  = (a_exp == fisd_pkg::EXP_MAX) && (a[51:0] == 52'd0);
	assign b_inf  = (b_exp == fisd_pkg::EXP_MAX) && (b[51:0] == 52'd0);
	assign a_zero = (a_exp == 11'd0) && (a[51:0] == 52'd0);
	assign b_zero = (b_exp == 11'd0) && (b[51:0] == 52'd0);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic        sign_s1, sign_s2, sign_s3, sign_s4, sign_s5, sign_s6;
	logic        nan_s1, nan_s2, nan_s3, nan_s4, nan_s5, nan_s6;
	logic        inf_s1, inf_s2, inf_s3, inf_s4, inf_s5, inf_s6;
	logic [11:0] esum_s1, esum_s2, esum_s3, esum_s4;
	logic [52:0] siga_s1, sigb_s1;
	logic [53:0] hh_s2;
	logic [52:0] hl_s2, lh_s2;
	logic [51:0] ll_s2;
	logic [53:0] hh_s3;
	logic [53:0] mid_s3;
	logic [51:0] ll_s3;
	logic [105:0] prod_s4, prod_s5;
	logic [6:0]  lz_s5;
	logic signed [13:0] exp_s5;
	logic        zero_s5, zero_s6;
	logic [52:0] man_s6;
	logic        grd_s6, stk_s6;
	logic [12:0] ebase_s6;

	// stage 6 shift control
	logic signed [13:0] sub_sh;
	logic [13:0] rs_full;
	logic [6:0]  rs;
	logic [6:0]  sl;
	logic        go_right;
	logic [12:0] ebase_c;
	logic [233:0] wide_r;
	logic [105:0] norm;
	logic        extra_stk;

	always_comb begin
		sub_sh   = $signed({7'b0, lz_s5}) + exp_s5 - 14'sd1;
		rs_full  = 14'(-sub_sh);
		rs       = (|rs_full[13:7]) ? 7'd127 : rs_full[6:0];
		go_right = 1'b0;
		sl       = lz_s5;
		ebase_c  = '0;
		if (exp_s5 >= 14'sd1) begin
			ebase_c = 13'(exp_s5 - 14'sd1);
		end else if (sub_sh[13]) begin
			go_right = 1'b1;
		end else begin
			sl = sub_sh[6:0];
		end
		wide_r = {prod_s5, 128'b0} >> rs;
		if (go_right) begin
			norm      = wide_r[233:128];
			extra_stk = |wide_r[127:0];
		end else begin
			norm      = prod_s5 << sl;
			extra_stk = 1'b0;
		end
	end

	// stage 7 rounding
	logic        inc;
	logic [53:0] mr;
	logic [64:0] packed_sum;
	logic        ovf;

	always_comb begin
		inc        = grd_s6 & (stk_s6 | man_s6[0]);
		mr         = {1'b0, man_s6} + {53'b0, inc};
		packed_sum = {ebase_s6, 52'b0} + {11'b0, mr};
		ovf        = packed_sum[64:52] >= 13'd2047;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			out_valid <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		// s1: unpack and classify
		sign_s1 <= a[63] ^ b[63];
		nan_s1  <= a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
		inf_s1  <= a_inf | b_inf;
		esum_s1 <= {1'b0, (a_exp == 11'd0) ? 11'd1 : a_exp}
			+ {1'b0, (b_exp == 11'd0) ? 11'd1 : b_exp};
		siga_s1 <= {a_exp != 11'd0, a[51:0]};
		sigb_s1 <= {b_exp != 11'd0, b[51:0]};
		// s2: partial products
		sign_s2 <= sign_s1;
		nan_s2  <= nan_s1;
		inf_s2  <= inf_s1;
		esum_s2 <= esum_s1;
		hh_s2   <= siga_s1[52:26] * sigb_s1[52:26];
		hl_s2   <= siga_s1[52:26] * sigb_s1[25:0];
		lh_s2   <= siga_s1[25:0] * sigb_s1[52:26];
		ll_s2   <= siga_s1[25:0] * sigb_s1[25:0];
		// s3: cross terms
		sign_s3 <= sign_s2;
		nan_s3  <= nan_s2;
		inf_s3  <= inf_s2;
		esum_s3 <= esum_s2;
		hh_s3   <= hh_s2;
		ll_s3   <= ll_s2;
		mid_s3  <= {1'b0, hl_s2} + {1'b0, lh_s2};
		// s4: full product
		sign_s4 <= sign_s3;
		nan_s4  <= nan_s3;
		inf_s4  <= inf_s3;
		esum_s4 <= esum_s3;
		prod_s4 <= {hh_s3, ll_s3} + {26'b0, mid_s3, 26'b0};
		// s5: leading zeros and exponent
		sign_s5 <= sign_s4;
		nan_s5  <= nan_s4;
		inf_s5  <= inf_s4;
		prod_s5 <= prod_s4;
		lz_s5   <= fisd_pkg::lzc106(prod_s4);
		exp_s5  <= $signed({2'b0, esum_s4}) - $signed({7'b0, fisd_pkg::lzc106(prod_s4)})
			- 14'sd1022;
		zero_s5 <= (prod_s4 == 106'd0);
		// s6: normalize or denormalize
		sign_s6  <= sign_s5;
		nan_s6   <= nan_s5;
		inf_s6   <= inf_s5;
		zero_s6  <= zero_s5;
		ebase_s6 <= ebase_c;
		man_s6   <= norm[105:53];
		grd_s6   <= norm[52];
		stk_s6   <= (|norm[51:0]) | extra_stk;
		// s7: round and pack
		if (nan_s6) begin
			y <= fisd_pkg::CANON_NAN;
		end else if (inf_s6 || (!zero_s6 && ovf)) begin
			y <= {sign_s6, fisd_pkg::EXP_MAX, 52'b0};
		end else if (zero_s6) begin
			y <= {sign_s6, 63'b0};
		end else begin
			y <= {sign_s6, packed_sum[62:0]};
		end
	end

	`FISD_ASSERT_IMP(a_fmul_lat, clk, arst_n, out_valid, $past(in_valid, fisd_pkg::FMUL_LAT))
	`FISD_ASSERT_IMP(a_fmul_nan_canon, clk, arst_n,
		out_valid && y[62:52] == fisd_pkg::EXP_MAX && y[51:0] != 52'd0,
		y == fisd_pkg::CANON_NAN)
	`FISD_ASSERT_IMP(a_fmul_nan_in, clk, arst_n,
		out_valid && $past(in_valid && a[62:52] == fisd_pkg::EXP_MAX && a[51:0] != 52'd0,
		fisd_pkg::FMUL_LAT), y == fisd_pkg::CANON_NAN)

endmodule
